// ----- sv/imq_pkg.sv -----
// Shared constants, codes and command/status types for the indexed minimum priority queue.
// Used by imq_ctrl, imq_datapath and indexed_min_priority_queue; depends on nothing.

package imq_pkg;

   localparam int VERTICES  = 64;
   localparam int VIDX_BITS = 6;
   localparam int KEY_BITS  = 32;
   localparam int CNT_BITS  = VIDX_BITS + 1;

   localparam logic [VIDX_BITS:0] SCAN_END = (VIDX_BITS + 1)'(VERTICES);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CHANGE = 2'd1;
   localparam logic [1:0] ACT_DELMIN = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_DUP    = 2'd3;

   typedef struct packed {
      logic latch;
      logic op_simple;
      logic op_empty;
      logic scan_clear;
      logic scan_run;
      logic take_min;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       count_zero;
      logic       scan_done;
      logic       out_free;
   } stat_type;

endpackage

// ----- sv/imq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; instanced by imq_datapath for the key store.

module imq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/imq_ctrl.sv -----
// Controller state machine of the priority queue: sequences accept, execute, scan and reply.
// Depends on imq_pkg for the command and status types and the action codes.

module imq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  imq_pkg::stat_type stat,
   output imq_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_REMOVE = 3'd3;
   localparam logic [2:0] S_PUSH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.action == imq_pkg::ACT_DELMIN) begin
               if (stat.count_zero) begin
                  cmd.op_empty = 1'b1;
                  state_in     = S_PUSH;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end
            end else begin
               cmd.op_simple = 1'b1;
               state_in      = S_PUSH;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            cmd.take_min = 1'b1;
            state_in     = S_PUSH;
         end
         S_PUSH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/imq_datapath.sv -----
// Datapath of the priority queue: request latch, occupancy bits, key RAM, minimum scan
// and the response register. Depends on imq_pkg and instances imq_ram.

module imq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  imq_pkg::cmd_type                 cmd,
   output imq_pkg::stat_type                stat,
   input  logic [1:0]                       req_action,
   input  logic [5:0]                       req_vertex,
   input  logic [31:0]                      req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [5:0]                       rsp_min_vertex,
   output logic                             rsp_present,
   output logic [1:0]                       rsp_status
);

   logic [1:0]                      action_ff;
   logic [imq_pkg::VIDX_BITS-1:0]   vertex_ff;
   logic [imq_pkg::KEY_BITS-1:0]    key_ff;
   logic [imq_pkg::VERTICES-1:0]    occ_ff;
   logic [imq_pkg::CNT_BITS-1:0]    count_ff;
   logic [imq_pkg::VIDX_BITS:0]     scan_idx_ff;
   logic                            cmp_valid_ff;
   logic [imq_pkg::VIDX_BITS-1:0]   cmp_idx_ff;
   logic                            found_ff;
   logic [imq_pkg::VIDX_BITS-1:0]   best_idx_ff;
   logic [imq_pkg::KEY_BITS-1:0]    best_key_ff;
   logic [imq_pkg::VIDX_BITS-1:0]   res_vertex_ff;
   logic                            res_present_ff;
   logic [1:0]                      res_status_ff;
   logic                            rsp_valid_ff;
   logic [5:0]                      rsp_min_vertex_ff;
   logic                            rsp_present_ff;
   logic [1:0]                      rsp_status_ff;

   logic                            occ_v;
   logic                            scan_issue;
   logic                            ram_wr_en;
   logic [imq_pkg::KEY_BITS-1:0]    ram_rd_data;
   logic                            better;

   assign occ_v      = occ_ff[vertex_ff];
   assign scan_issue = cmd.scan_run && (scan_idx_ff != imq_pkg::SCAN_END);
   assign ram_wr_en  = cmd.op_simple &&
                       (((action_ff == imq_pkg::ACT_INSERT) && !occ_v) ||
                        ((action_ff == imq_pkg::ACT_CHANGE) && occ_v));
   assign better     = cmp_valid_ff && occ_ff[cmp_idx_ff] &&
                       (!found_ff || (ram_rd_data < best_key_ff));

   imq_ram #(
      .WIDTH(imq_pkg::KEY_BITS),
      .DEPTH(imq_pkg::VERTICES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (vertex_ff),
      .wr_data (key_ff),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff[imq_pkg::VIDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   assign stat.action     = action_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_done  = (scan_idx_ff == imq_pkg::SCAN_END) && !cmp_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_action;
         vertex_ff <= req_vertex;
         key_ff    <= req_key[imq_pkg::KEY_BITS-1:0];
      end

      if (cmd.scan_clear) begin
         scan_idx_ff <= '0;
      end else if (scan_issue) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      cmp_idx_ff <= scan_idx_ff[imq_pkg::VIDX_BITS-1:0];
      if (better) begin
         best_idx_ff <= cmp_idx_ff;
         best_key_ff <= ram_rd_data;
      end

      if (cmd.op_simple) begin
         res_vertex_ff  <= '0;
         res_present_ff <= (action_ff == imq_pkg::ACT_QUERY) && occ_v;
         unique case (action_ff)
            imq_pkg::ACT_INSERT: res_status_ff <= occ_v ? imq_pkg::ST_DUP : imq_pkg::ST_OK;
            imq_pkg::ACT_CHANGE: res_status_ff <= occ_v ? imq_pkg::ST_OK : imq_pkg::ST_ABSENT;
            default:             res_status_ff <= imq_pkg::ST_OK;
         endcase
      end else if (cmd.op_empty) begin
         res_vertex_ff  <= '0;
         res_present_ff <= 1'b0;
         res_status_ff  <= imq_pkg::ST_EMPTY;
      end else if (cmd.take_min) begin
         res_vertex_ff  <= found_ff ? best_idx_ff : '0;
         res_present_ff <= 1'b0;
         res_status_ff  <= found_ff ? imq_pkg::ST_OK : imq_pkg::ST_EMPTY;
      end

      if (cmd.push) begin
         rsp_min_vertex_ff <= res_vertex_ff;
         rsp_present_ff    <= res_present_ff;
         rsp_status_ff     <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= scan_issue;

         if (cmd.scan_clear) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end

         if (cmd.op_simple && (action_ff == imq_pkg::ACT_INSERT) && !occ_v) begin
            occ_ff[vertex_ff] <= 1'b1;
            count_ff          <= count_ff + 1'b1;
         end else if (cmd.take_min && found_ff) begin
            occ_ff[best_idx_ff] <= 1'b0;
            count_ff            <= count_ff - 1'b1;
         end

         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_vertex = rsp_min_vertex_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- sv/indexed_min_priority_queue.sv -----
// Top level of the indexed minimum priority queue: joins controller and datapath.
// Depends on imq_pkg, imq_ctrl, imq_datapath and imq_ram.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   action, vertex, key
//   rsp_      out        rsp_valid / rsp_ready   min_vertex, present, status
//
// One request is worked on at a time. Insert, change, query and delete minimum on an empty
// queue pass through the execute state straight to the response load.
// Delete minimum otherwise scans all 64 keys through one comparator, then removes the winner
// and loads the response; the next request is taken only after the response is loaded.
// Reset is synchronous and empties the queue at once; the key RAM is never cleared.
// A held response stalls the next result in its final cycle, and with it the input side.

module indexed_min_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_vertex,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_min_vertex,
   output logic        rsp_present,
   output logic [1:0]  rsp_status
);

   imq_pkg::cmd_type  cmd;
   imq_pkg::stat_type stat;

   imq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   imq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_vertex     (req_vertex),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_vertex (rsp_min_vertex),
      .rsp_present    (rsp_present),
      .rsp_status     (rsp_status)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Second request accepted while one is in progress.");

   a_empty_no_vertex: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == imq_pkg::ST_EMPTY)) |-> (rsp_min_vertex == 6'd0))
      else $error("Empty-queue response carries a vertex.");

   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_present) |-> (rsp_status == imq_pkg::ST_OK))
      else $error("Present flag set on a response with error status.");

   a_scan_then_push: assert property (@(posedge clock) disable iff (reset)
      cmd.take_min |=> !req_ready)
      else $error("Removal of the minimum did not lead to a response.");

endmodule
